// File: rtl/hrv_window_coherence_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef HRV_WINDOW_COHERENCE_MACROS_SVH
`define HRV_WINDOW_COHERENCE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRV_ASSERT_NOW(lbl, ant, con, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (con)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HRV_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (con)) \
        else $error(msg);

`endif

// File: rtl/hrv_wc_pkg.sv
package hrv_wc_pkg;

    localparam int HR_W      = 16;
    localparam int OUT_W     = 16;
    localparam int RAD_W     = 34;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int COH_SHIFT = 28;
    localparam int TDATA_W   = 5 * OUT_W;
    localparam int TUSER_W   = 2;

endpackage

// File: rtl/hrv_wc_mul.sv
module hrv_wc_mul #(
    parameter int W = 55
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           go,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic           done,
    output logic [2*W-1:0] p
);

    localparam int CW = $clog2(W + 1);

    logic [2*W-1:0] acc_reg;
    logic [2*W-1:0] mc_reg;
    logic [W-1:0]   mp_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !go && busy_reg && (cnt_reg == CW'(W - 1));
            if (go) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            acc_reg <= '0;
            mc_reg  <= (2*W)'(a);
            mp_reg  <= b;
        end else if (busy_reg) begin
            if (mp_reg[0]) begin
                acc_reg <= acc_reg + mc_reg;
            end
            mc_reg <= mc_reg << 1;
            mp_reg <= mp_reg >> 1;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

// File: rtl/hrv_wc_div.sv
module hrv_wc_div #(
    parameter int W = 138
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         go,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  dv_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W:0]    trial;
    logic          ge;

    always_comb begin
        trial = {rem_reg, quo_reg[W-1]};
        ge    = trial >= {1'b0, dv_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !go && busy_reg && (cnt_reg == CW'(W - 1));
            if (go) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dv_reg  <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? W'(trial - {1'b0, dv_reg}) : trial[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/hrv_wc_sqrt.sv
module hrv_wc_sqrt #(
    parameter int RW = 34
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            go,
    input  logic [RW-1:0]   radicand,
    output logic            done,
    output logic [RW/2-1:0] root
);

    localparam int H  = RW / 2;
    localparam int CW = $clog2(H + 1);

    logic [RW-1:0] rad_reg;
    logic [H-1:0]  root_reg;
    logic [H:0]    rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [H+2:0]  shifted;
    logic [H+2:0]  trial;
    logic          ge;

    always_comb begin
        shifted = {rem_reg, rad_reg[RW-1 -: 2]};
        trial   = {1'b0, root_reg, 2'b01};
        ge      = shifted >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !go && busy_reg && (cnt_reg == CW'(H - 1));
            if (go) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(H - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            rad_reg  <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= ge ? (H+1)'(shifted - trial) : shifted[H:0];
            root_reg <= {root_reg[H-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: rtl/hrv_wc_win.sv
module hrv_wc_win #(
    parameter int N  = 64,
    parameter int SW = 23,
    parameter int QW = 39
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [hrv_wc_pkg::HR_W-1:0] wr_data,
    input  logic                        sweep_go,
    output logic                        sweep_done,
    output logic [SW-1:0]               sum_o,
    output logic [QW-1:0]               sq_o,
    output logic [QW-1:0]               lag_o,
    output logic [QW-1:0]               dsq_o,
    output logic [hrv_wc_pkg::HR_W-1:0] first_o,
    output logic [hrv_wc_pkg::HR_W-1:0] last_o,
    output logic [2*hrv_wc_pkg::HR_W-1:0] first_sq_o,
    output logic [2*hrv_wc_pkg::HR_W-1:0] last_sq_o
);

    localparam int AW = $clog2(N);
    localparam int LW = $clog2(N + 1);
    localparam int HW = hrv_wc_pkg::HR_W;

    logic [HW-1:0]   mem [N];
    logic [AW-1:0]   wp_reg;
    logic [AW-1:0]   rp_reg;
    logic [LW-1:0]   cnt_reg;
    logic            iss_reg;
    logic            rv_reg;
    logic            rfirst_reg;
    logic            rlast_reg;
    logic            done_reg;
    logic [HW-1:0]   rdata_reg;
    logic [HW-1:0]   prev_reg;
    logic [SW-1:0]   sum_reg;
    logic [QW-1:0]   sq_reg;
    logic [QW-1:0]   lag_reg;
    logic [QW-1:0]   dsq_reg;
    logic [HW-1:0]   first_reg;
    logic [HW-1:0]   last_reg;
    logic [2*HW-1:0] first_sq_reg;
    logic [2*HW-1:0] last_sq_reg;
    logic [HW-1:0]   diff;
    logic [2*HW-1:0] w_sq;
    logic [2*HW-1:0] w_lag;
    logic [2*HW-1:0] w_dsq;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wp_reg] <= wr_data;
        end
        rdata_reg <= mem[rp_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg     <= '0;
            rp_reg     <= '0;
            cnt_reg    <= '0;
            iss_reg    <= 1'b0;
            rv_reg     <= 1'b0;
            rfirst_reg <= 1'b0;
            rlast_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            rv_reg     <= iss_reg;
            rfirst_reg <= iss_reg && (cnt_reg == '0);
            rlast_reg  <= iss_reg && (cnt_reg == LW'(N - 1));
            done_reg   <= rv_reg && rlast_reg;
            if (wr_en) begin
                wp_reg <= (wp_reg == AW'(N - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (sweep_go) begin
                iss_reg <= 1'b1;
                cnt_reg <= '0;
                rp_reg  <= wp_reg;
            end else if (iss_reg) begin
                rp_reg  <= (rp_reg == AW'(N - 1)) ? '0 : rp_reg + 1'b1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LW'(N - 1)) begin
                    iss_reg <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        diff  = (rdata_reg > prev_reg) ? rdata_reg - prev_reg : prev_reg - rdata_reg;
        w_sq  = (2*HW)'(rdata_reg) * (2*HW)'(rdata_reg);
        w_lag = (2*HW)'(prev_reg) * (2*HW)'(rdata_reg);
        w_dsq = (2*HW)'(diff) * (2*HW)'(diff);
    end

    always_ff @(posedge aclk) begin
        if (sweep_go) begin
            sum_reg <= '0;
            sq_reg  <= '0;
            lag_reg <= '0;
            dsq_reg <= '0;
        end else if (rv_reg) begin
            prev_reg <= rdata_reg;
            sum_reg  <= sum_reg + SW'(rdata_reg);
            sq_reg   <= sq_reg + QW'(w_sq);
            if (!rfirst_reg) begin
                lag_reg <= lag_reg + QW'(w_lag);
                dsq_reg <= dsq_reg + QW'(w_dsq);
            end
            if (rfirst_reg) begin
                first_reg    <= rdata_reg;
                first_sq_reg <= w_sq;
            end
            if (rlast_reg) begin
                last_reg    <= rdata_reg;
                last_sq_reg <= w_sq;
            end
        end
    end

    assign sweep_done = done_reg;
    assign sum_o      = sum_reg;
    assign sq_o       = sq_reg;
    assign lag_o      = lag_reg;
    assign dsq_o      = dsq_reg;
    assign first_o    = first_reg;
    assign last_o     = last_reg;
    assign first_sq_o = first_sq_reg;
    assign last_sq_o  = last_sq_reg;

endmodule

// File: rtl/hrv_window_coherence.sv
// Heart-rate variability over a sliding window of WINDOW_LEN unsigned Q8.8 samples. Until the
// window is full, each request returns an all-zero result. Once full, each request yields the
// window mean, SDNN, RMSSD, the lag-1 coherence and, every AVG_COUNT windows, the averaged
// coherence. The multiplier works on NW-bit operands and the divider on DW-bit operands, where
// NW = 3*ceil(log2(WINDOW_LEN+1)) + 34 and DW = 2*NW + 28. The time is set by the bit-serial
// multiplier, divider and square-root unit, each retiring one bit per cycle; each is shared by
// all steps of the calculation that use it. A new request is taken once the previous result
// has been loaded into the output register, even while that result still waits there.
`include "hrv_window_coherence_macros.svh"

module hrv_window_coherence #(
    parameter int WINDOW_LEN = 64,
    parameter int AVG_COUNT  = 5
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // heart_rate
    input  logic [hrv_wc_pkg::HR_W-1:0]    s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // mean_rate, sdnn, rmssd, coherence_now, coherence_avg
    output logic [hrv_wc_pkg::TDATA_W-1:0] m_tdata,
    // window_full, coherence_ready
    output logic [hrv_wc_pkg::TUSER_W-1:0] m_tuser
);

    localparam int HW  = hrv_wc_pkg::HR_W;
    localparam int OW  = hrv_wc_pkg::OUT_W;
    localparam int RW  = hrv_wc_pkg::RAD_W;
    localparam int RTW = hrv_wc_pkg::ROOT_W;
    localparam int LW  = $clog2(WINDOW_LEN + 1);
    localparam int SW  = HW + LW;
    localparam int QW  = 2 * HW + LW;
    localparam int NW  = 3 * LW + 2 * HW + 2;
    localparam int DW  = 2 * NW + hrv_wc_pkg::COH_SHIFT;
    localparam int CSW = OW + $clog2(AVG_COUNT + 1);
    localparam int PW  = $clog2(AVG_COUNT + 1);

    localparam logic [NW-1:0] N_C   = NW'(WINDOW_LEN);
    localparam logic [NW-1:0] NN_C  = NW'(WINDOW_LEN * WINDOW_LEN);
    localparam logic [NW-1:0] NM1_C = NW'(WINDOW_LEN - 1);
    localparam logic [NW-1:0] N2_C  = NW'(2 * WINDOW_LEN);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SWEEP = 6'b000010,
        ST_ISSUE = 6'b000100,
        ST_WAIT  = 6'b001000,
        ST_ACC   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    typedef enum logic [4:0] {
        OP_SS, OP_ST1, OP_ST2, OP_ST3, OP_NA, OP_NQ, OP_NQ1, OP_NQ2,
        OP_MSS, OP_NT1, OP_NT2, OP_NT3, OP_MEAN, OP_VAR, OP_SD, OP_RQ,
        OP_RM, OP_DD, OP_MM, OP_CQ, OP_COH, OP_AVG
    } op_t;

    state_t state_reg;
    op_t    op_reg;
    logic [LW-1:0]  fill_reg;
    logic [PW-1:0]  phase_reg;
    logic signed [CSW-1:0] csum_reg;
    logic           sweep_go_reg;
    logic           m_tvalid_reg;
    logic [hrv_wc_pkg::TDATA_W-1:0] m_tdata_reg;
    logic [hrv_wc_pkg::TUSER_W-1:0] m_tuser_reg;

    logic [NW-1:0] ss_reg, t1_reg, t2_reg, t3_reg, na_reg, nq_reg, nq1_reg, nq2_reg;
    logic [NW-1:0] mss_reg, nt1_reg, nt2_reg, nt3_reg;
    logic [NW-1:0] varn_reg, num_reg, d1_reg, d2_reg, mag_reg;
    logic [2*NW-1:0] dd_reg, mm_reg;
    logic [RW-1:0]  rad_reg;
    logic [OW-1:0]  mean_reg, sd_reg, rm_reg;
    logic signed [OW-1:0] coh_reg, avg_reg;
    logic [CSW-1:0] avg_mag_reg;
    logic           avg_neg_reg;
    logic           full_reg;
    logic           ready_reg;

    logic s_accept;
    logic short_item;
    logic out_load;
    logic win_done;
    logic [SW-1:0] win_sum;
    logic [QW-1:0] win_sq, win_lag, win_dsq;
    logic [HW-1:0] win_first, win_last;
    logic [2*HW-1:0] win_first_sq, win_last_sq;

    logic use_mul, use_div, use_sqrt;
    logic mul_go, div_go, sqrt_go;
    logic mul_done, div_done, sqrt_done, unit_done;
    logic [NW-1:0] mul_a, mul_b;
    logic [2*NW-1:0] mul_p;
    logic [DW-1:0] div_n, div_d, div_q;
    logic [RW-1:0] sqrt_x;
    logic [RTW-1:0] sqrt_r;
    logic coh_zero;
    logic signed [CSW-1:0] csum_new;
    logic [OW-1:0] root_sat;
    logic [2:0] go_vec;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign short_item = s_accept && (fill_reg < LW'(WINDOW_LEN - 1));
    assign out_load   = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign unit_done  = mul_done || div_done || sqrt_done;
    assign coh_zero   = (d1_reg == '0) || (d2_reg == '0);
    assign csum_new   = csum_reg + CSW'(coh_reg);
    assign root_sat   = sqrt_r[RTW-1] ? {OW{1'b1}} : sqrt_r[OW-1:0];

    hrv_wc_win #(.N(WINDOW_LEN), .SW(SW), .QW(QW)) u_win (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (s_accept),
        .wr_data    (s_tdata),
        .sweep_go   (sweep_go_reg),
        .sweep_done (win_done),
        .sum_o      (win_sum),
        .sq_o       (win_sq),
        .lag_o      (win_lag),
        .dsq_o      (win_dsq),
        .first_o    (win_first),
        .last_o     (win_last),
        .first_sq_o (win_first_sq),
        .last_sq_o  (win_last_sq)
    );

    hrv_wc_mul #(.W(NW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (mul_go),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    hrv_wc_div #(.W(DW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (div_go),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    hrv_wc_sqrt #(.RW(RW)) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (sqrt_go),
        .radicand (sqrt_x),
        .done     (sqrt_done),
        .root     (sqrt_r)
    );

    always_comb begin
        use_mul  = 1'b0;
        use_div  = 1'b0;
        use_sqrt = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        div_n    = '0;
        div_d    = '0;
        sqrt_x   = rad_reg;
        case (op_reg)
            OP_SS: begin
                use_mul = 1'b1;
                mul_a   = NW'(win_sum);
                mul_b   = NW'(win_sum);
            end
            OP_ST1: begin
                use_mul = 1'b1;
                mul_a   = NW'(win_sum);
                mul_b   = NW'(win_sum) + NW'(win_sum) - NW'(win_first) - NW'(win_last);
            end
            OP_ST2: begin
                use_mul = 1'b1;
                mul_a   = NW'(win_sum);
                mul_b   = NW'(win_sum) - NW'(win_last);
            end
            OP_ST3: begin
                use_mul = 1'b1;
                mul_a   = NW'(win_sum);
                mul_b   = NW'(win_sum) - NW'(win_first);
            end
            OP_NA: begin
                use_mul = 1'b1;
                mul_a   = NN_C;
                mul_b   = NW'(win_lag);
            end
            OP_NQ: begin
                use_mul = 1'b1;
                mul_a   = N_C;
                mul_b   = NW'(win_sq);
            end
            OP_NQ1: begin
                use_mul = 1'b1;
                mul_a   = NN_C;
                mul_b   = NW'(win_sq) - NW'(win_last_sq);
            end
            OP_NQ2: begin
                use_mul = 1'b1;
                mul_a   = NN_C;
                mul_b   = NW'(win_sq) - NW'(win_first_sq);
            end
            OP_MSS: begin
                use_mul = 1'b1;
                mul_a   = NM1_C;
                mul_b   = ss_reg;
            end
            OP_NT1: begin
                use_mul = 1'b1;
                mul_a   = N_C;
                mul_b   = t1_reg;
            end
            OP_NT2: begin
                use_mul = 1'b1;
                mul_a   = N2_C;
                mul_b   = t2_reg;
            end
            OP_NT3: begin
                use_mul = 1'b1;
                mul_a   = N2_C;
                mul_b   = t3_reg;
            end
            OP_MEAN: begin
                use_div = 1'b1;
                div_n   = DW'(win_sum);
                div_d   = DW'(WINDOW_LEN);
            end
            OP_VAR: begin
                use_div = 1'b1;
                div_n   = DW'(varn_reg);
                div_d   = DW'(WINDOW_LEN * (WINDOW_LEN - 1));
            end
            OP_RQ: begin
                use_div = 1'b1;
                div_n   = DW'(win_dsq);
                div_d   = DW'(WINDOW_LEN - 1);
            end
            OP_SD, OP_RM, OP_COH: begin
                use_sqrt = 1'b1;
            end
            OP_DD: begin
                use_mul = 1'b1;
                mul_a   = d1_reg;
                mul_b   = d2_reg;
            end
            OP_MM: begin
                use_mul = 1'b1;
                mul_a   = mag_reg;
                mul_b   = mag_reg;
            end
            OP_CQ: begin
                use_div = 1'b1;
                div_n   = DW'(mm_reg) << hrv_wc_pkg::COH_SHIFT;
                div_d   = DW'(dd_reg);
            end
            OP_AVG: begin
                use_div = 1'b1;
                div_n   = DW'(avg_mag_reg);
                div_d   = DW'(AVG_COUNT);
            end
            default: begin
                use_mul = 1'b0;
            end
        endcase
    end

    assign mul_go  = (state_reg == ST_ISSUE) && use_mul;
    assign div_go  = (state_reg == ST_ISSUE) && use_div;
    assign sqrt_go = (state_reg == ST_ISSUE) && use_sqrt;
    assign go_vec  = {mul_go, div_go, sqrt_go};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_SS;
            fill_reg     <= '0;
            phase_reg    <= '0;
            csum_reg     <= '0;
            sweep_go_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            sweep_go_reg <= s_accept && !short_item;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (fill_reg != LW'(WINDOW_LEN)) begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        if (short_item) begin
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_SWEEP;
                        end
                    end
                end
                ST_SWEEP: begin
                    if (win_done) begin
                        op_reg    <= OP_SS;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (unit_done) begin
                        case (op_reg)
                            OP_RM: begin
                                if (coh_zero) begin
                                    state_reg <= ST_ACC;
                                end else begin
                                    op_reg    <= OP_DD;
                                    state_reg <= ST_ISSUE;
                                end
                            end
                            OP_COH: begin
                                state_reg <= ST_ACC;
                            end
                            OP_AVG: begin
                                state_reg <= ST_OUT;
                            end
                            default: begin
                                op_reg    <= op_t'(op_reg + 5'd1);
                                state_reg <= ST_ISSUE;
                            end
                        endcase
                    end
                end
                ST_ACC: begin
                    phase_reg <= (phase_reg == PW'(AVG_COUNT - 1)) ? '0 : phase_reg + 1'b1;
                    if (phase_reg == '0) begin
                        csum_reg  <= '0;
                        op_reg    <= OP_AVG;
                        state_reg <= ST_ISSUE;
                    end else begin
                        csum_reg  <= csum_new;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        varn_reg <= nq_reg - ss_reg;
        num_reg  <= na_reg + mss_reg - nt1_reg;
        d1_reg   <= nq1_reg + mss_reg - nt2_reg;
        d2_reg   <= nq2_reg + mss_reg - nt3_reg;
        mag_reg  <= num_reg[NW-1] ? NW'(-num_reg) : num_reg;

        if (s_accept) begin
            full_reg  <= !short_item;
            ready_reg <= 1'b0;
        end

        if ((state_reg == ST_WAIT) && unit_done) begin
            case (op_reg)
                OP_SS:   ss_reg   <= mul_p[NW-1:0];
                OP_ST1:  t1_reg   <= mul_p[NW-1:0];
                OP_ST2:  t2_reg   <= mul_p[NW-1:0];
                OP_ST3:  t3_reg   <= mul_p[NW-1:0];
                OP_NA:   na_reg   <= mul_p[NW-1:0];
                OP_NQ:   nq_reg   <= mul_p[NW-1:0];
                OP_NQ1:  nq1_reg  <= mul_p[NW-1:0];
                OP_NQ2:  nq2_reg  <= mul_p[NW-1:0];
                OP_MSS:  mss_reg  <= mul_p[NW-1:0];
                OP_NT1:  nt1_reg  <= mul_p[NW-1:0];
                OP_NT2:  nt2_reg  <= mul_p[NW-1:0];
                OP_NT3:  nt3_reg  <= mul_p[NW-1:0];
                OP_MEAN: mean_reg <= div_q[OW-1:0];
                OP_VAR, OP_RQ, OP_CQ: begin
                    rad_reg <= div_q[RW-1:0];
                end
                OP_SD:   sd_reg   <= root_sat;
                OP_RM: begin
                    rm_reg <= root_sat;
                    if (coh_zero) begin
                        coh_reg <= '0;
                    end
                end
                OP_DD:   dd_reg   <= mul_p;
                OP_MM:   mm_reg   <= mul_p;
                OP_COH: begin
                    coh_reg <= num_reg[NW-1] ? OW'(-sqrt_r) : OW'(sqrt_r);
                end
                OP_AVG: begin
                    avg_reg <= avg_neg_reg ? OW'(-div_q) : OW'(div_q);
                end
                default: begin
                    mean_reg <= mean_reg;
                end
            endcase
        end

        if (state_reg == ST_ACC) begin
            ready_reg   <= (phase_reg == '0);
            avg_neg_reg <= csum_new[CSW-1];
            avg_mag_reg <= csum_new[CSW-1] ? CSW'(-csum_new) : CSW'(csum_new);
            if (phase_reg != '0) begin
                avg_reg <= '0;
            end
        end

        if (out_load) begin
            if (full_reg) begin
                m_tdata_reg <= {avg_reg, coh_reg, rm_reg, sd_reg, mean_reg};
                m_tuser_reg <= {ready_reg, 1'b1};
            end else begin
                m_tdata_reg <= '0;
                m_tuser_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `HRV_ASSERT_NOW(a_one_unit, 1'b1, $onehot0(go_vec), "Two units started together.")
    `HRV_ASSERT_NOW(a_sweep_state, win_done, state_reg == ST_SWEEP, "Sweep ended out of state.")
    `HRV_ASSERT_NEXT(a_short_item, short_item, state_reg == ST_OUT, "Short request not sent.")
    `HRV_ASSERT_NOW(a_ready_full, m_tvalid && m_tuser[1], m_tuser[0], "Average without window.")

endmodule

// File: sim/hrv_window_coherence_test.sv
`timescale 1ns / 1ps

module hrv_window_coherence_test;

    localparam int WLEN = 64;
    localparam int NAVG = 5;
    localparam longint CYCLE_LIMIT = 40000000;

    typedef struct packed {
        logic        window_full;
        logic        coherence_ready;
        logic [15:0] mean_rate;
        logic [15:0] sdnn;
        logic [15:0] rmssd;
        logic [15:0] coherence_now;
        logic [15:0] coherence_avg;
    } hrv_result_t;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [hrv_wc_pkg::HR_W-1:0]        s_tdata = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [hrv_wc_pkg::TDATA_W-1:0]     m_tdata;
    logic [hrv_wc_pkg::TUSER_W-1:0]     m_tuser;

    hrv_window_coherence #(.WINDOW_LEN(WLEN), .AVG_COUNT(NAVG)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #1 aclk = ~aclk;

    logic [15:0]  pending_samples[$];
    hrv_result_t  expected_stats[$];
    int           sender_idle_pct = 0;
    int           receiver_stall_pct = 0;
    logic         hold_off_request = 1'b0;
    int           hold_off_left = 0;
    logic         request_taken = 1'b0;
    int           mismatches = 0;
    longint       cycle_count = 0;

    // Predictor state for the sliding window.
    logic [15:0]  hr_window[WLEN];
    int           held_count = 0;
    int           phase_count = 0;
    longint       coh_accum = 0;

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        logic [127:0] r, t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (128'd1 << b);
            if (t * t <= v) r = t;
        end
        return r[63:0];
    endfunction

    function automatic int coherence_scale(longint unsigned mag, longint d1, longint d2);
        logic [255:0] prod, limit, t;
        int lo, hi, mid;
        prod = 256'(d1) * 256'(d2);
        limit = (256'(mag) * 256'(mag)) << hrv_wc_pkg::COH_SHIFT;
        lo = 0;
        hi = 16384;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = prod * 256'(mid * mid);
            if (t <= limit) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic hrv_result_t window_stats(logic [15:0] x);
        hrv_result_t r;
        longint s, q, a, d, w, p, first, last, s1, s2, q1, q2, num, d1, d2, v;
        longint unsigned sd, rm;
        int coh;
        r = '0;
        if (held_count < WLEN) begin
            hr_window[held_count] = x;
            held_count++;
        end else begin
            for (int i = 0; i < WLEN - 1; i++) hr_window[i] = hr_window[i + 1];
            hr_window[WLEN - 1] = x;
        end
        if (held_count < WLEN) return r;
        s = 0; q = 0; a = 0; d = 0;
        for (int i = 0; i < WLEN; i++) begin
            w = hr_window[i];
            s += w;
            q += w * w;
            if (i > 0) begin
                p = hr_window[i - 1];
                a += p * w;
                d += (w - p) * (w - p);
            end
        end
        v = (WLEN * q - s * s) / (WLEN * (WLEN - 1));
        sd = floor_sqrt(v);
        rm = floor_sqrt(d / (WLEN - 1));
        first = hr_window[0];
        last = hr_window[WLEN - 1];
        s1 = s - last;
        s2 = s - first;
        q1 = q - last * last;
        q2 = q - first * first;
        num = WLEN * WLEN * a + (WLEN - 1) * s * s - WLEN * s * (s1 + s2);
        d1 = WLEN * WLEN * q1 + (WLEN - 1) * s * s - 2 * WLEN * s * s1;
        d2 = WLEN * WLEN * q2 + (WLEN - 1) * s * s - 2 * WLEN * s * s2;
        coh = 0;
        if (d1 != 0 && d2 != 0) begin
            coh = coherence_scale(num < 0 ? -num : num, d1, d2);
            if (num < 0) coh = -coh;
        end
        coh_accum += coh;
        r.window_full = 1'b1;
        r.mean_rate = 16'(s / WLEN);
        r.sdnn = sd > 65535 ? 16'hFFFF : 16'(sd);
        r.rmssd = rm > 65535 ? 16'hFFFF : 16'(rm);
        r.coherence_now = 16'(coh);
        if (phase_count == 0) begin
            r.coherence_ready = 1'b1;
            r.coherence_avg = 16'(coh_accum / NAVG);
            coh_accum = 0;
        end
        phase_count = (phase_count + 1) % NAVG;
        return r;
    endfunction

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !request_taken) begin
            s_tvalid <= 1'b1;
        end else if (pending_samples.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            s_tvalid <= 1'b1;
            s_tdata <= pending_samples[0];
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (hold_off_request && hold_off_left == 0) begin
            hold_off_left <= 20000;
            m_tready <= 1'b0;
        end else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            m_tready <= (hold_off_left == 1);
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge aclk) begin
        hrv_result_t got, want;
        request_taken <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            expected_stats.push_back(window_stats(s_tdata));
            void'(pending_samples.pop_front());
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.window_full = m_tuser[0];
            got.coherence_ready = m_tuser[1];
            {got.coherence_avg, got.coherence_now, got.rmssd, got.sdnn, got.mean_rate} =
                m_tdata;
            if (expected_stats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result: %p", got);
            end else begin
                want = expected_stats.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic queue_random(int count, int full_range_pct);
        logic [15:0] base;
        base = 16'($urandom_range(15360, 40960));
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < full_range_pct)
                pending_samples.push_back(16'($urandom));
            else
                pending_samples.push_back(base + 16'($urandom_range(0, 2047)) - 16'd1024);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Fill the window, then run a constant window at each extreme, an alternating run and a ramp.
        queue_random(WLEN, 50);
        repeat (WLEN + 2) pending_samples.push_back(16'hFFFF);
        repeat (WLEN + 2) pending_samples.push_back(16'h0000);
        for (int i = 0; i < 24; i++) pending_samples.push_back(i[0] ? 16'hFFFF : 16'h0000);
        for (int i = 0; i < 8; i++) pending_samples.push_back(16'(i * 8191));
        wait (pending_samples.size() == 0);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 55; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 55; end
                3: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
                default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            endcase
            queue_random(200, 30);
            if (ph == 4) begin
                @(negedge aclk);
                hold_off_request <= 1'b1;
                @(negedge aclk);
                hold_off_request <= 1'b0;
            end
            wait (pending_samples.size() == 0);
        end

        wait (expected_stats.size() == 0);
        repeat (4000) @(posedge aclk);
        if (mismatches == 0 && expected_stats.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
